[sv/bmsa_pkg.sv]
// ----------------------------------------------------------------------------
// Block map sector allocator package
// Shared widths, codes and types for the allocator, its map memory and its
// track evaluation unit.
// ----------------------------------------------------------------------------
package bmsa_pkg;

    localparam int NUM_TRACKS   = 35;
    localparam int SCAN_SECTORS = 21;

    localparam int TRACK_W  = 6;
    localparam int SECTOR_W = 5;
    localparam int COUNT_W  = 8;
    localparam int BITMAP_W = 24;
    localparam int TOTAL_W  = 14;
    localparam int TRK_AW   = $clog2(NUM_TRACKS);

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USED_W = 2 + TRACK_W + SECTOR_W + COUNT_W + BITMAP_W + TOTAL_W;

    localparam logic [TRACK_W-1:0] DEFAULT_HINT = TRACK_W'(17);
    localparam logic [TRACK_W-1:0] DIR_TRACK    = TRACK_W'(18);
    localparam logic [TRACK_W-1:0] UPPER_START  = TRACK_W'(19);
    localparam logic [TRACK_W-1:0] LAST_TRACK   = TRACK_W'(NUM_TRACKS);
    localparam logic [TRACK_W-1:0] FIRST_TRACK  = TRACK_W'(1);

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = TOTAL_W'((NUM_TRACKS - 1) * 255);

    // Highest disk mode in which allocation with fallback is allowed.
    localparam logic [1:0] MODE_ALLOC_MAX = 2'd1;

    typedef enum logic [2:0] {
        OP_LOAD     = 3'd0,
        OP_READ     = 3'd1,
        OP_ALLOC    = 3'd2,
        OP_ALLOC_ON = 3'd3,
        OP_FREE     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NO_FREE      = 2'd1,
        STAT_ALREADY_FREE = 2'd2,
        STAT_RANGE        = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        K_READ = 2'd0,
        K_LOAD = 2'd1,
        K_TAKE = 2'd2,
        K_FREE = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RD   = 2'd1,
        ST_EV   = 2'd2,
        ST_OUT  = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        PH_HINT   = 2'd0,
        PH_DOWN   = 2'd1,
        PH_UP     = 2'd2,
        PH_REPORT = 2'd3
    } phase_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [BITMAP_W-1:0] bitmap;
    } entry_t;

    typedef struct packed {
        logic                wr_en;
        logic                taken;
        status_t             status;
        logic [SECTOR_W-1:0] sector;
        entry_t              entry;
    } eval_res_t;

endpackage

[sv/bmsa_mem.sv]
// ----------------------------------------------------------------------------
// Block map memory
// One entry per track, one write and one registered read port. Per-entry
// valid bits make a never written entry read as zero after reset.
// ----------------------------------------------------------------------------
module bmsa_mem
    import bmsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [TRK_AW-1:0] wr_addr,
    input  entry_t            wr_data,
    input  logic              rd_en,
    input  logic [TRK_AW-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t                  mem [NUM_TRACKS];
    logic [NUM_TRACKS-1:0]   valid_reg;
    entry_t                  rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

[sv/bmsa_eval.sv]
// ----------------------------------------------------------------------------
// Track evaluation unit
// Applies one operation to one track entry: load, read, take the lowest
// free sector, or free a sector. Shared by every track the search visits.
// ----------------------------------------------------------------------------
module bmsa_eval
    import bmsa_pkg::*;
(
    input  kind_t               kind,
    input  entry_t              old_entry,
    input  entry_t              load_entry,
    input  logic [SECTOR_W-1:0] sector,
    output eval_res_t           res
);

    logic                found;
    logic [SECTOR_W-1:0] low_idx;
    logic [BITMAP_W-1:0] sec_mask;

    // Lowest free sector within the scanned range.
    always_comb begin
        found   = 1'b0;
        low_idx = '0;
        for (int i = SCAN_SECTORS - 1; i >= 0; i--) begin
            if (old_entry.bitmap[i]) begin
                found   = 1'b1;
                low_idx = SECTOR_W'(i);
            end
        end
    end

    always_comb begin
        res        = '0;
        res.status = STAT_OK;
        res.entry  = old_entry;
        sec_mask   = BITMAP_W'(1) << sector;
        case (kind)
            K_LOAD: begin
                res.wr_en = 1'b1;
                res.entry = load_entry;
            end
            K_TAKE: begin
                if (old_entry.count == '0) begin
                    res.status = STAT_NO_FREE;
                end else if (found) begin
                    res.wr_en        = 1'b1;
                    res.taken        = 1'b1;
                    res.sector       = low_idx;
                    res.entry.bitmap = old_entry.bitmap & ~(BITMAP_W'(1) << low_idx);
                    res.entry.count  = old_entry.count - 1'b1;
                end else begin
                    // Count says free but the bitmap disagrees: clear the count.
                    res.wr_en       = 1'b1;
                    res.status      = STAT_NO_FREE;
                    res.entry.count = '0;
                end
            end
            K_FREE: begin
                if (sector >= SECTOR_W'(BITMAP_W)) begin
                    res.status = STAT_RANGE;
                end else if ((old_entry.bitmap & sec_mask) != '0) begin
                    res.status = STAT_ALREADY_FREE;
                end else begin
                    res.wr_en        = 1'b1;
                    res.entry.bitmap = old_entry.bitmap | sec_mask;
                    res.entry.count  = old_entry.count + 1'b1;
                end
            end
            default: begin
                res.entry = old_entry;
            end
        endcase
    end

endmodule

[sv/block_map_sector_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Block map sector allocator
// Per-track free counts and bitmaps with load, read, allocate and free.
// ----------------------------------------------------------------------------
// One item is handled at a time. Every track the item touches is read from
// the map memory and then evaluated in the shared track unit, which writes
// the entry back in the same cycle. Load, read, free and allocate on one
// track visit one track; an item with a track out of range visits no track.
// Allocation with fallback visits the hint track, then 17 down to 1 and 19
// up to the last track, and when all fail reads the hint track once more
// for the report. The next item can be taken in the cycle after the result
// register is loaded. A result still waiting for m_tready holds the next
// result back in ST_OUT until the waiting result is taken. The total free
// count is kept as a running sum, updated as each entry outside the
// directory track is written back.
// s_tready is high only while no item is in progress; a finished result may
// still wait in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module block_map_sector_allocator_unit
    import bmsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: disk_mode
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // track[5:0], sector[10:6], load_count[18:11], load_bitmap[42:19], zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation[2:0]
    input  logic [2:0]            s_tuser,
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[1:0], result_track[7:2], result_sector[12:8], entry_count[20:13],
    // entry_bitmap[44:21], total_free[58:45], zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    op_t                  op_reg, op_next;
    logic [TRACK_W-1:0]   cur_track_reg, cur_track_next;
    logic [TRACK_W-1:0]   first_track_reg, first_track_next;
    logic [SECTOR_W-1:0]  sector_reg, sector_next;
    entry_t               load_reg, load_next;
    logic [1:0]           disk_mode_reg;
    logic [TOTAL_W-1:0]   total_reg, total_next;

    status_t              res_status_reg, res_status_next;
    logic [TRACK_W-1:0]   res_track_reg, res_track_next;
    logic [SECTOR_W-1:0]  res_sector_reg, res_sector_next;
    entry_t               res_entry_reg, res_entry_next;

    logic                 m_valid_reg, m_valid_next;
    logic [OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                 accept;
    logic [TRACK_W-1:0]   in_track;
    logic [TRACK_W-1:0]   in_track_res;
    logic                 in_track_ok;
    op_t                  in_op;

    logic                 mem_wr_en;
    logic                 mem_rd_en;
    logic [TRK_AW-1:0]    mem_addr;
    entry_t               mem_rd_data;

    kind_t                kind;
    logic                 force_no_free;
    eval_res_t            ev;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign in_op        = op_t'(s_tuser);
    assign in_track     = s_tdata[TRACK_W-1:0];
    assign in_track_res = (in_op == OP_ALLOC && in_track == '0) ? DEFAULT_HINT : in_track;
    assign in_track_ok  = (in_track_res != '0) && (in_track_res <= LAST_TRACK);

    assign mem_addr  = TRK_AW'(cur_track_reg - 1'b1);
    assign mem_rd_en = (state_reg == ST_RD);
    assign mem_wr_en = (state_reg == ST_EV) && ev.wr_en;

    bmsa_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_addr),
        .wr_data (ev.entry),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_addr),
        .rd_data (mem_rd_data)
    );

    // Map the operation onto what the shared unit does for this visit.
    always_comb begin
        kind          = K_READ;
        force_no_free = 1'b0;
        if (phase_reg == PH_REPORT) begin
            force_no_free = 1'b1;
        end else begin
            case (op_reg)
                OP_LOAD: kind = K_LOAD;
                OP_ALLOC: begin
                    if (disk_mode_reg > MODE_ALLOC_MAX) begin
                        force_no_free = 1'b1;
                    end else begin
                        kind = K_TAKE;
                    end
                end
                OP_ALLOC_ON: kind = K_TAKE;
                OP_FREE:     kind = K_FREE;
                default:     kind = K_READ;
            endcase
        end
    end

    bmsa_eval u_eval (
        .kind       (kind),
        .old_entry  (mem_rd_data),
        .load_entry (load_reg),
        .sector     (sector_reg),
        .res        (ev)
    );

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        op_next          = op_reg;
        cur_track_next   = cur_track_reg;
        first_track_next = first_track_reg;
        sector_next      = sector_reg;
        load_next        = load_reg;
        total_next       = total_reg;
        res_status_next  = res_status_reg;
        res_track_next   = res_track_reg;
        res_sector_next  = res_sector_reg;
        res_entry_next   = res_entry_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next          = in_op;
                    cur_track_next   = in_track_res;
                    first_track_next = in_track_res;
                    sector_next      = s_tdata[10:6];
                    load_next.count  = s_tdata[18:11];
                    load_next.bitmap = s_tdata[42:19];
                    phase_next       = PH_HINT;
                    if (in_track_ok) begin
                        state_next = ST_RD;
                    end else begin
                        res_status_next = STAT_RANGE;
                        res_track_next  = in_track_res;
                        res_sector_next = '0;
                        res_entry_next  = '0;
                        state_next      = ST_OUT;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_EV;
            end
            ST_EV: begin
                if (ev.wr_en && cur_track_reg != DIR_TRACK) begin
                    total_next = total_reg + TOTAL_W'(ev.entry.count)
                                 - TOTAL_W'(mem_rd_data.count);
                end
                if (kind == K_TAKE && op_reg == OP_ALLOC && !ev.taken) begin
                    // Move on in the fallback order; the hint is read again
                    // for the report once every track has failed.
                    state_next = ST_RD;
                    case (phase_reg)
                        PH_HINT: begin
                            phase_next     = PH_DOWN;
                            cur_track_next = DEFAULT_HINT;
                        end
                        PH_DOWN: begin
                            if (cur_track_reg == FIRST_TRACK) begin
                                phase_next     = PH_UP;
                                cur_track_next = UPPER_START;
                            end else begin
                                cur_track_next = cur_track_reg - 1'b1;
                            end
                        end
                        default: begin
                            if (cur_track_reg == LAST_TRACK) begin
                                phase_next     = PH_REPORT;
                                cur_track_next = first_track_reg;
                            end else begin
                                cur_track_next = cur_track_reg + 1'b1;
                            end
                        end
                    endcase
                end else begin
                    res_status_next = force_no_free ? STAT_NO_FREE : ev.status;
                    res_track_next  = cur_track_reg;
                    res_sector_next = ev.sector;
                    res_entry_next  = ev.entry;
                    state_next      = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {(OUT_DATA_W - OUT_USED_W)'(0), total_reg,
                                    res_entry_reg.bitmap, res_entry_reg.count,
                                    res_sector_reg, res_track_reg, res_status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_HINT;
            m_valid_reg   <= 1'b0;
            disk_mode_reg <= '0;
            total_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            total_reg   <= total_next;
            if (cfg_wr_en) begin
                disk_mode_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        cur_track_reg   <= cur_track_next;
        first_track_reg <= first_track_next;
        sector_reg      <= sector_next;
        load_reg        <= load_next;
        res_status_reg  <= res_status_next;
        res_track_reg   <= res_track_next;
        res_sector_reg  <= res_sector_next;
        res_entry_reg   <= res_entry_next;
        m_data_reg      <= m_data_next;
    end

    // The map is only written while a track is being evaluated.
    a_write_in_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> state_reg == ST_EV)
        else $error("map written outside the evaluation step");

    // Every memory read addresses an existing track.
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |-> (cur_track_reg != '0 && cur_track_reg <= LAST_TRACK))
        else $error("map read at a track out of range");

    // The running total can never exceed the sum of full counts.
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOTAL_MAX)
        else $error("running free total out of bounds");

    // Changes to the directory track leave the total untouched.
    a_dir_excluded: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en && cur_track_reg == DIR_TRACK |=> total_reg == $past(total_reg))
        else $error("directory track counted in the free total");

endmodule

[bench/block_map_checker.sv]
// ----------------------------------------------------------------------------
// Block map checker
// Watches the configuration port and both stream channels of the sector
// allocator. It keeps its own copy of the track map, works out the result of
// every accepted item, and compares each result with the oldest one owed.
// ----------------------------------------------------------------------------
module block_map_checker
    import bmsa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [2:0]            s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    error_count,
    output int                    results_owed
);

    typedef struct packed {
        status_t             status;
        logic [TRACK_W-1:0]  track;
        logic [SECTOR_W-1:0] sector;
        logic [COUNT_W-1:0]  count;
        logic [BITMAP_W-1:0] bitmap;
        logic [TOTAL_W-1:0]  total;
    } map_result_t;

    logic [COUNT_W-1:0]  track_count  [1:NUM_TRACKS];
    logic [BITMAP_W-1:0] track_bitmap [1:NUM_TRACKS];
    logic [1:0]          disk_mode;
    map_result_t         expected_results [$];

    function automatic bit track_valid(input int t);
        return t >= 1 && t <= NUM_TRACKS;
    endfunction

    // A track with a nonzero count but no free bit in the scan range loses
    // its count, even though nothing is allocated there.
    function automatic bit take_sector(input int t, output logic [SECTOR_W-1:0] sec);
        sec = '0;
        if (track_count[t] == '0)
            return 1'b0;
        for (int i = 0; i < SCAN_SECTORS && i < BITMAP_W; i++) begin
            if (track_bitmap[t][i]) begin
                track_bitmap[t][i] = 1'b0;
                track_count[t]     = track_count[t] - 1'b1;
                sec                = SECTOR_W'(i);
                return 1'b1;
            end
        end
        track_count[t] = '0;
        return 1'b0;
    endfunction

    function automatic logic [TOTAL_W-1:0] free_total();
        int sum;
        sum = 0;
        for (int t = 1; t <= NUM_TRACKS; t++)
            if (t != DIR_TRACK)
                sum += track_count[t];
        return TOTAL_W'(sum);
    endfunction

    function automatic map_result_t predict_map_op(
        input logic [2:0]          op_code,
        input logic [TRACK_W-1:0]  trk_in,
        input logic [SECTOR_W-1:0] sec_in,
        input logic [COUNT_W-1:0]  cnt_in,
        input logic [BITMAP_W-1:0] bm_in
    );
        map_result_t         r;
        int                  trk;
        int                  hint;
        logic [SECTOR_W-1:0] got;
        bit                  found;
        r.status = STAT_OK;
        r.sector = '0;
        found    = 1'b0;
        trk      = trk_in;
        if (op_code == OP_ALLOC && trk == 0)
            trk = DEFAULT_HINT;
        if (!track_valid(trk)) begin
            r.status = STAT_RANGE;
        end else begin
            case (op_code)
                OP_LOAD: begin
                    track_count[trk]  = cnt_in;
                    track_bitmap[trk] = bm_in;
                end
                OP_ALLOC: begin
                    if (disk_mode > MODE_ALLOC_MAX) begin
                        r.status = STAT_NO_FREE;
                    end else if (take_sector(trk, got)) begin
                        r.sector = got;
                    end else begin
                        hint = trk;
                        for (int t = DEFAULT_HINT; t >= 1 && !found; t--) begin
                            if (take_sector(t, got)) begin
                                trk   = t;
                                found = 1'b1;
                            end
                        end
                        for (int t = UPPER_START; t <= NUM_TRACKS && !found; t++) begin
                            if (take_sector(t, got)) begin
                                trk   = t;
                                found = 1'b1;
                            end
                        end
                        if (found) begin
                            r.sector = got;
                        end else begin
                            r.status = STAT_NO_FREE;
                            trk      = hint;
                        end
                    end
                end
                OP_ALLOC_ON: begin
                    if (take_sector(trk, got))
                        r.sector = got;
                    else
                        r.status = STAT_NO_FREE;
                end
                OP_FREE: begin
                    if (sec_in >= BITMAP_W) begin
                        r.status = STAT_RANGE;
                    end else if (track_bitmap[trk][sec_in]) begin
                        r.status = STAT_ALREADY_FREE;
                    end else begin
                        track_bitmap[trk][sec_in] = 1'b1;
                        track_count[trk]          = track_count[trk] + 1'b1;
                    end
                end
                // Read and the unused codes leave the map alone.
                default: ;
            endcase
        end
        r.track = TRACK_W'(trk);
        if (track_valid(trk)) begin
            r.count  = track_count[trk];
            r.bitmap = track_bitmap[trk];
        end else begin
            r.count  = '0;
            r.bitmap = '0;
        end
        r.total = free_total();
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        map_result_t want;
        map_result_t seen;
        if (!aresetn) begin
            for (int t = 1; t <= NUM_TRACKS; t++) begin
                track_count[t]  = '0;
                track_bitmap[t] = '0;
            end
            disk_mode = '0;
            expected_results.delete();
            error_count = 0;
        end else begin
            if (cfg_wr_en)
                disk_mode = cfg_wr_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_map_op(s_tuser, s_tdata[5:0],
                    s_tdata[10:6], s_tdata[18:11], s_tdata[42:19]));
            if (m_tvalid && m_tready) begin
                seen.status = status_t'(m_tdata[1:0]);
                seen.track  = m_tdata[7:2];
                seen.sector = m_tdata[12:8];
                seen.count  = m_tdata[20:13];
                seen.bitmap = m_tdata[44:21];
                seen.total  = m_tdata[58:45];
                if (expected_results.size() == 0) begin
                    if (error_count < 10)
                        $display("unexpected result item: status %0d track %0d sector %0d",
                            seen.status, seen.track, seen.sector);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (seen !== want) begin
                        if (error_count < 10) begin
                            $display("result mismatch at %0t", $realtime);
                            $display("  expected status %0d track %0d sector %0d count %0d bitmap %06h total %0d",
                                want.status, want.track, want.sector, want.count,
                                want.bitmap, want.total);
                            $display("  actual   status %0d track %0d sector %0d count %0d bitmap %06h total %0d",
                                seen.status, seen.track, seen.sector, seen.count,
                                seen.bitmap, seen.total);
                        end
                        error_count++;
                    end
                end
            end
        end
        results_owed <= expected_results.size();
    end

endmodule

[bench/block_map_sector_allocator_unit_tb.sv]
// ----------------------------------------------------------------------------
// Block map sector allocator testbench
// Drives directed and random map operations through the allocator under
// four disk modes and changing back pressure, with the checker judging
// every result item.
// ----------------------------------------------------------------------------
module block_map_sector_allocator_unit_tb;
    import bmsa_pkg::*;

    localparam logic [1:0] MODE_SINGLE   = 2'd0;
    localparam logic [1:0] MODE_DOUBLE   = 2'd1;
    localparam logic [1:0] MODE_HIGH_CAP = 2'd2;
    localparam logic [1:0] MODE_SPARE    = 2'd3;

    // Operation codes the block treats as a read.
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic [1:0]            cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata     = '0;
    logic [2:0]            s_tuser     = '0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int error_count;
    int results_owed;
    int send_gap_pct   = 9;
    int recv_stall_pct = 80;

    block_map_sector_allocator_unit u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    block_map_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_item(
        input logic [2:0]          op,
        input logic [TRACK_W-1:0]  trk,
        input logic [SECTOR_W-1:0] sec,
        input logic [COUNT_W-1:0]  cnt,
        input logic [BITMAP_W-1:0] bm
    );
        if ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_DATA_W'({bm, cnt, sec, trk});
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the input channel until every owed result item has been taken.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_mode(input logic [1:0] mode);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random_item();
        logic [2:0]          op;
        logic [TRACK_W-1:0]  trk;
        logic [SECTOR_W-1:0] sec;
        logic [COUNT_W-1:0]  cnt;
        logic [BITMAP_W-1:0] bm;
        int                  pick;
        pick = $urandom_range(0, 99);
        if (pick < 14)
            op = OP_LOAD;
        else if (pick < 22)
            op = OP_READ;
        else if (pick < 52)
            op = OP_ALLOC;
        else if (pick < 67)
            op = OP_ALLOC_ON;
        else if (pick < 95)
            op = OP_FREE;
        else
            op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

        pick = $urandom_range(0, 99);
        if (pick < 6)
            trk = TRACK_W'($urandom_range(NUM_TRACKS + 1, 63));
        else if (pick < 10)
            trk = '0;
        else
            trk = TRACK_W'($urandom_range(1, NUM_TRACKS));

        if ($urandom_range(0, 99) < 8)
            sec = SECTOR_W'($urandom_range(BITMAP_W, 31));
        else
            sec = SECTOR_W'($urandom_range(0, BITMAP_W - 1));

        // Bitmaps range from full to sparse to free bits only past the scan
        // range, which makes the count get forced to zero on allocation.
        case ($urandom_range(0, 3))
            0: bm = BITMAP_W'($urandom);
            1: bm = BITMAP_W'((1 << $urandom_range(0, 23)) | (1 << $urandom_range(0, 23)));
            2: bm = '1;
            default: bm = BITMAP_W'($urandom_range(1, 7) << SCAN_SECTORS);
        endcase

        case ($urandom_range(0, 3))
            0, 1: cnt = COUNT_W'($countones(bm));
            2: cnt = COUNT_W'($urandom_range(0, 255));
            default: cnt = $urandom_range(0, 1) ? '1 : '0;
        endcase

        send_item(op, trk, sec, cnt, bm);
    endtask

    task automatic run_phase(input logic [1:0] mode, input int gap, input int stall,
                             input int n);
        set_mode(mode);
        send_gap_pct = gap;
        recv_stall_pct <= stall;
        repeat (n) send_random_item();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty map: the fallback search finds nothing.
        send_item(OP_ALLOC, 6'd0, 5'd0, 8'd0, 24'h0);
        send_item(OP_READ, 6'd0, 5'd0, 8'd0, 24'h0);
        send_item(OP_READ, 6'd63, 5'd0, 8'd0, 24'h0);
        // Only the last scanned sector of an upper track is free.
        send_item(OP_LOAD, 6'd20, 5'd0, 8'd1, 24'h100000);
        send_item(OP_ALLOC, 6'd0, 5'd0, 8'd0, 24'h0);
        send_item(OP_LOAD, 6'd1, 5'd0, 8'd255, 24'hFFFFFF);
        send_item(OP_LOAD, 6'd18, 5'd0, 8'd5, 24'h00001F);
        send_item(OP_LOAD, 6'd17, 5'd0, 8'd3, 24'hE00000);
        send_item(OP_LOAD, 6'd36, 5'd0, 8'd9, 24'h0000FF);
        send_item(OP_ALLOC, 6'd0, 5'd0, 8'd0, 24'h0);
        send_item(OP_ALLOC, 6'd18, 5'd0, 8'd0, 24'h0);
        send_item(OP_ALLOC_ON, 6'd35, 5'd0, 8'd0, 24'h0);
        send_item(OP_ALLOC_ON, 6'd1, 5'd0, 8'd0, 24'h0);
        send_item(OP_FREE, 6'd1, 5'd0, 8'd0, 24'h0);
        send_item(OP_FREE, 6'd1, 5'd0, 8'd0, 24'h0);
        send_item(OP_FREE, 6'd1, 5'd23, 8'd0, 24'h0);
        send_item(OP_FREE, 6'd1, 5'd31, 8'd0, 24'h0);
        send_item(OP_FREE, 6'd0, 5'd3, 8'd0, 24'h0);
        // A free on a full count wraps it to zero.
        send_item(OP_LOAD, 6'd2, 5'd0, 8'd255, 24'h0);
        send_item(OP_FREE, 6'd2, 5'd5, 8'd0, 24'h0);
        send_item(OP_SPARE_FIRST, 6'd1, 5'd0, 8'd0, 24'h0);
        send_item(OP_SPARE_LAST, 6'd35, 5'd0, 8'd0, 24'h0);
        send_item(OP_ALLOC, 6'd40, 5'd0, 8'd0, 24'h0);
        set_mode(MODE_HIGH_CAP);
        send_item(OP_ALLOC, 6'd1, 5'd0, 8'd0, 24'h0);
        send_item(OP_ALLOC_ON, 6'd1, 5'd0, 8'd0, 24'h0);

        run_phase(MODE_DOUBLE, 9, 80, 280);
        run_phase(MODE_SPARE, 9, 80, 40);
        run_phase(MODE_SINGLE, 80, 9, 240);
        run_phase(MODE_HIGH_CAP, 80, 9, 50);
        run_phase(MODE_SINGLE, 0, 0, 240);

        wait_idle();
        repeat (80) @(posedge aclk);
        if (error_count == 0 && results_owed == 0)
            $display("PASS block_map_sector_allocator_unit");
        else
            $display("FAIL block_map_sector_allocator_unit");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL block_map_sector_allocator_unit");
        $finish;
    end

endmodule

[sim.f]
sv/bmsa_pkg.sv
sv/bmsa_mem.sv
sv/bmsa_eval.sv
sv/block_map_sector_allocator_unit.sv
bench/block_map_checker.sv
bench/block_map_sector_allocator_unit_tb.sv
